@@ rtl/tcc_pkg.sv @@
// Shared constants and types of the text console cursor and scroll block.
// Depends on nothing; the cursor, the top level and the bench take names from here by scope.
package tcc_pkg;

	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] CODE_NL    = 8'h0A;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam logic [7:0] CODE_BS    = 8'h08;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic wr_byte;
		logic clr_row;
		logic scrolled;
		logic rd_cell;
	} tcc_op_t;

endpackage

@@ rtl/tcc_if.sv @@
// Valid/ready channel interfaces for the console request and response.
// Depends on nothing.
interface tcc_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_code;
	logic [4:0] read_row;
	logic [4:0] read_col;

	modport source (output valid, mode, char_code, read_row, read_col, input ready);
	modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [4:0] cursor_col;
	logic [4:0] cursor_row;
	logic       scrolled;

	modport source (output valid, cell_char, cursor_col, cursor_row, scrolled, input ready);
	modport sink   (input valid, cell_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

@@ rtl/text_console_cursor_scroll.sv @@
// Text console engine: one request per cycle, each answered by one response once
// its transfer has passed the memory read stage and then the output register. The
// screen lives in a row-wide memory, one word per row, with a registered read; a put
// reads its row, merges the byte and writes the row back, and a row written by the
// item just ahead is forwarded to the next item. Scrolling advances a row-ring
// pointer and marks the old top row blank through a per-row valid bit, so it moves
// no row data; reset blanks all rows at once and needs no clearing pass.
// Throughput drops below one item per cycle only while the response side stalls.
module text_console_cursor_scroll #(
	parameter int LINE_STRIDE  = 32,
	parameter int VISIBLE_COLS = 30,
	parameter int ROWS         = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	tcc_req_if.sink   req,
	tcc_rsp_if.source rsp
);

	localparam int YW = $clog2(ROWS);
	localparam int CW = $clog2(LINE_STRIDE);
	localparam int RW = LINE_STRIDE * 8;
	localparam logic [RW-1:0] SPACE_ROW = {LINE_STRIDE{tcc_pkg::CODE_SPACE}};

	logic                 acc;
	logic                 adv;
	tcc_pkg::tcc_op_t     acc_op;
	logic [YW-1:0]        acc_addr;
	logic [CW-1:0]        acc_col;
	logic [YW-1:0]        acc_clr;
	logic [4:0]           acc_ccol;
	logic [4:0]           acc_crow;

	logic [RW-1:0]        mem [ROWS];
	logic [ROWS-1:0]      row_vld_q;

	logic                 vld_s1;
	tcc_pkg::tcc_op_t     op_s1;
	logic [YW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	logic [YW-1:0]        clr_s1;
	logic [7:0]           byte_s1;
	logic [4:0]           ccol_s1;
	logic [4:0]           crow_s1;
	logic [RW-1:0]        rdata_s1;
	logic                 fwd_hit_s1;
	logic [RW-1:0]        fwd_data_s1;

	logic [RW-1:0]        eff_row;
	logic [RW-1:0]        new_row;
	logic [7:0]           rd_byte;

	logic                 out_vld_q;
	logic [7:0]           cell_q;
	logic [4:0]           ccol_q;
	logic [4:0]           crow_q;
	logic                 scrolled_q;

	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = !vld_s1 || adv;
	assign acc       = req.valid && req.ready;

	tcc_cursor #(
		.LINE_STRIDE (LINE_STRIDE),
		.VISIBLE_COLS(VISIBLE_COLS),
		.ROWS        (ROWS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (acc),
		.mode      (req.mode),
		.char_code (req.char_code),
		.read_row  (req.read_row),
		.read_col  (req.read_col),
		.op        (acc_op),
		.addr      (acc_addr),
		.col       (acc_col),
		.clr_addr  (acc_clr),
		.cursor_col(acc_ccol),
		.cursor_row(acc_crow)
	);

	// merge against forwarded or stored row; blank rows read as spaces
	always_comb begin
		if (fwd_hit_s1) begin
			eff_row = fwd_data_s1;
		end else if (row_vld_q[row_s1]) begin
			eff_row = rdata_s1;
		end else begin
			eff_row = SPACE_ROW;
		end
		new_row = eff_row;
		if (op_s1.wr_byte) begin
			new_row[col_s1*8 +: 8] = byte_s1;
		end
		rd_byte = op_s1.rd_cell ? eff_row[col_s1*8 +: 8] : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= mem[acc_addr];
		end
		if (adv && vld_s1 && op_s1.wr_byte) begin
			mem[row_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (adv && vld_s1) begin
			if (op_s1.wr_byte) begin
				row_vld_q[row_s1] <= 1'b1;
			end
			if (op_s1.clr_row) begin
				row_vld_q[clr_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// hold stage payload until the next transfer
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1       <= acc_op;
			row_s1      <= acc_addr;
			col_s1      <= acc_col;
			clr_s1      <= acc_clr;
			byte_s1     <= req.char_code;
			ccol_s1     <= acc_ccol;
			crow_s1     <= acc_crow;
			fwd_hit_s1  <= vld_s1 && op_s1.wr_byte && (row_s1 == acc_addr);
			fwd_data_s1 <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			cell_q     <= rd_byte;
			ccol_q     <= ccol_s1;
			crow_q     <= crow_s1;
			scrolled_q <= op_s1.scrolled;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.cell_char  = cell_q;
	assign rsp.cursor_col = ccol_q;
	assign rsp.cursor_row = crow_q;
	assign rsp.scrolled   = scrolled_q;

endmodule

@@ rtl/tcc_cursor.sv @@
// Cursor, row-ring pointer and per-item decode of the text console.
// Depends on tcc_pkg for character codes, modes and the operation struct.
module tcc_cursor #(
	parameter int LINE_STRIDE  = 32,
	parameter int VISIBLE_COLS = 30,
	parameter int ROWS         = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        mode,
	input  logic [7:0]                  char_code,
	input  logic [4:0]                  read_row,
	input  logic [4:0]                  read_col,
	output tcc_pkg::tcc_op_t            op,
	output logic [$clog2(ROWS)-1:0]        addr,
	output logic [$clog2(LINE_STRIDE)-1:0] col,
	output logic [$clog2(ROWS)-1:0]        clr_addr,
	output logic [4:0]                  cursor_col,
	output logic [4:0]                  cursor_row
);

	localparam int XW = $clog2(VISIBLE_COLS + 1);
	localparam int YW = $clog2(ROWS);
	localparam int CW = $clog2(LINE_STRIDE);

	logic [XW-1:0] x_q, x_d, x_inc;
	logic [YW-1:0] y_q, y_d;
	logic [YW-1:0] top_q, top_d;
	logic          adv_row;
	logic          rd_ok;

	function automatic logic [YW-1:0] phys(input logic [YW-1:0] r, input logic [YW-1:0] top);
		logic [YW:0] s;
		s = {1'b0, r} + {1'b0, top};
		if (32'(s) >= ROWS) begin
			s = s - (YW+1)'(ROWS);
		end
		return s[YW-1:0];
	endfunction

	always_comb begin
		x_d     = x_q;
		y_d     = y_q;
		top_d   = top_q;
		op      = '0;
		adv_row = 1'b0;
		x_inc   = x_q + XW'(1);
		rd_ok   = (32'(read_row) < ROWS) && (32'(read_col) < LINE_STRIDE);
		if (mode == tcc_pkg::MODE_READ) begin
			op.rd_cell = rd_ok;
		end else begin
			case (char_code)
				tcc_pkg::CODE_NL: begin
					adv_row = 1'b1;
				end
				tcc_pkg::CODE_CR: begin
					x_d = '0;
				end
				tcc_pkg::CODE_BS: begin
					if (x_q != '0) begin
						x_d = x_q - XW'(1);
					end
				end
				default: begin
					op.wr_byte = (32'(x_q) < LINE_STRIDE);
					if (32'(x_inc) >= VISIBLE_COLS) begin
						adv_row = 1'b1;
					end else begin
						x_d = x_inc;
					end
				end
			endcase
		end
		if (adv_row) begin
			x_d = '0;
			if (32'(y_q) + 1 >= ROWS) begin
				y_d         = YW'(ROWS - 1);
				op.clr_row  = 1'b1;
				op.scrolled = 1'b1;
				top_d       = (top_q == YW'(ROWS - 1)) ? '0 : top_q + YW'(1);
			end else begin
				y_d = y_q + YW'(1);
			end
		end
	end

	assign addr       = (mode == tcc_pkg::MODE_READ) ? phys(YW'(read_row), top_q)
	                                                 : phys(y_q, top_q);
	assign col        = (mode == tcc_pkg::MODE_READ) ? CW'(read_col) : CW'(x_q);
	assign clr_addr   = top_q;
	assign cursor_col = 5'(x_d);
	assign cursor_row = 5'(y_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			top_q <= '0;
		end else if (accept) begin
			x_q   <= x_d;
			y_q   <= y_d;
			top_q <= top_d;
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for text_console_cursor_scroll: drives put and read transfers,
// predicts every response from a private screen model and checks each field in order.
// Depends on tcc_pkg, the tcc_req_if / tcc_rsp_if channels and the console top level.
module tb;

	localparam int LINE_STRIDE  = 32;
	localparam int VISIBLE_COLS = 30;
	localparam int ROWS         = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 6;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [4:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} console_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	tcc_req_if req_ch ();
	tcc_rsp_if rsp_ch ();

	text_console_cursor_scroll #(
		.LINE_STRIDE (LINE_STRIDE),
		.VISIBLE_COLS(VISIBLE_COLS),
		.ROWS        (ROWS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	logic [7:0]   screen_mem [ROWS][LINE_STRIDE];
	int           cur_col;
	int           cur_row;
	int           top_phys;
	console_rsp_t pending_rsp [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int err_count   = 0;
	int items_sent  = 0;
	int rsp_checked = 0;
	int scroll_seen = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic bit advance_row();
		cur_col = 0;
		if (cur_row + 1 >= ROWS) begin
			cur_row = ROWS - 1;
			for (int c = 0; c < LINE_STRIDE; c++)
				screen_mem[top_phys][c] = tcc_pkg::CODE_SPACE;
			top_phys = (top_phys + 1) % ROWS;
			return 1'b1;
		end
		cur_row++;
		return 1'b0;
	endfunction

	function automatic console_rsp_t console_apply(input logic mode, input logic [7:0] code,
			input logic [4:0] rrow, input logic [4:0] rcol);
		console_rsp_t r;
		r = '0;
		if (mode == tcc_pkg::MODE_READ) begin
			if (rrow < ROWS && rcol < LINE_STRIDE)
				r.cell_char = screen_mem[(int'(rrow) + top_phys) % ROWS][rcol];
		end else if (code == tcc_pkg::CODE_NL) begin
			r.scrolled = advance_row();
		end else if (code == tcc_pkg::CODE_CR) begin
			cur_col = 0;
		end else if (code == tcc_pkg::CODE_BS) begin
			if (cur_col > 0)
				cur_col--;
		end else begin
			if (cur_col < LINE_STRIDE && cur_row < ROWS)
				screen_mem[(cur_row + top_phys) % ROWS][cur_col] = code;
			cur_col++;
			if (cur_col >= VISIBLE_COLS)
				r.scrolled = advance_row();
		end
		r.cursor_col = cur_col[4:0];
		r.cursor_row = cur_row[4:0];
		return r;
	endfunction

	task automatic send_cmd(input logic mode, input logic [7:0] code,
			input logic [4:0] rrow, input logic [4:0] rcol);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= mode;
		req_ch.char_code <= code;
		req_ch.read_row  <= rrow;
		req_ch.read_col  <= rcol;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(console_apply(mode, code, rrow, rcol));
		items_sent++;
	endtask

	task automatic put_char(input logic [7:0] code);
		send_cmd(tcc_pkg::MODE_PUT, code, 5'($urandom), 5'($urandom));
	endtask

	task automatic read_cell(input logic [4:0] rrow, input logic [4:0] rcol);
		send_cmd(tcc_pkg::MODE_READ, 8'($urandom), rrow, rcol);
	endtask

	task automatic test_directed();
		read_cell(5'd0, 5'd0);
		read_cell(5'd19, 5'd31);
		read_cell(5'd20, 5'd0);
		read_cell(5'd31, 5'd31);
		put_char(tcc_pkg::CODE_BS);
		put_char(8'h00);
		put_char(8'hFF);
		send_cmd(tcc_pkg::MODE_PUT, 8'h41, 5'h1F, 5'h1F);
		send_cmd(tcc_pkg::MODE_READ, 8'hFF, 5'd0, 5'd0);
		send_cmd(tcc_pkg::MODE_READ, 8'h00, 5'd0, 5'd1);
		put_char(tcc_pkg::CODE_BS);
		put_char(8'h42);
		read_cell(5'd0, 5'd2);
		put_char(tcc_pkg::CODE_CR);
		read_cell(5'd0, 5'd29);
		put_char(tcc_pkg::CODE_NL);
		put_char(8'h7F);
		read_cell(5'd1, 5'd0);
		read_cell(5'd0, 5'd3);
		put_char(tcc_pkg::CODE_NL);
		read_cell(5'd2, 5'd30);
	endtask

	task automatic test_text_stream(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 9)
				put_char(tcc_pkg::CODE_NL);
			else if (pick < 12)
				put_char(tcc_pkg::CODE_CR);
			else if (pick < 17)
				put_char(tcc_pkg::CODE_BS);
			else if (pick < 22)
				read_cell(5'($urandom), 5'($urandom));
			else if (pick < 32)
				read_cell(5'($urandom_range(0, ROWS - 1)), 5'($urandom));
			else if (pick < 40)
				put_char(8'($urandom));
			else
				put_char(8'($urandom_range(8'h20, 8'h7E)));
		end
	endtask

	task automatic test_long_lines(input int lines);
		int len;
		for (int l = 0; l < lines; l++) begin
			len = $urandom_range(25, 70);
			for (int i = 0; i < len; i++)
				put_char(8'($urandom_range(8'h21, 8'hFE)) | 8'h10);
			for (int i = 0; i < 4; i++)
				read_cell(5'(cur_row), 5'($urandom));
		end
	endtask

	task automatic test_read_sweep(input int count);
		for (int i = 0; i < count; i++)
			read_cell(5'($urandom_range(0, ROWS + 1)), 5'($urandom));
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	always @(posedge clk)
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		console_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report("response transfer with nothing expected");
			end else begin
				want = pending_rsp.pop_front();
				rsp_checked++;
				if (rsp_ch.scrolled === 1'b1)
					scroll_seen++;
				if (rsp_ch.cell_char !== want.cell_char)
					report($sformatf("cell_char got %h want %h", rsp_ch.cell_char,
						want.cell_char));
				if (rsp_ch.cursor_col !== want.cursor_col)
					report($sformatf("cursor_col got %0d want %0d", rsp_ch.cursor_col,
						want.cursor_col));
				if (rsp_ch.cursor_row !== want.cursor_row)
					report($sformatf("cursor_row got %0d want %0d", rsp_ch.cursor_row,
						want.cursor_row));
				if (rsp_ch.scrolled !== want.scrolled)
					report($sformatf("scrolled got %b want %b", rsp_ch.scrolled,
						want.scrolled));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_console_cursor_scroll verification failed");
			$finish;
		end
	end

	initial begin
		int waited;
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < LINE_STRIDE; c++)
				screen_mem[r][c] = tcc_pkg::CODE_SPACE;
		cur_col  = 0;
		cur_row  = 0;
		top_phys = 0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.mode      <= tcc_pkg::MODE_PUT;
		req_ch.char_code <= '0;
		req_ch.read_row  <= '0;
		req_ch.read_col  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(18, 65);
		test_directed();
		test_text_stream(100);
		test_long_lines(2);
		test_read_sweep(25);

		set_idling(65, 18);
		test_text_stream(100);
		test_long_lines(2);
		test_read_sweep(25);

		set_idling(0, 0);
		test_text_stream(100);
		test_long_lines(2);
		test_read_sweep(25);

		req_ch.valid <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			report($sformatf("%0d responses never arrived", pending_rsp.size()));

		$display("Ran %0d requests (puts, controls, reads), checked %0d responses, %0d scrolls.",
			items_sent, rsp_checked, scroll_seen);
		$display("Mismatches reported: %0d", err_count);
		if (err_count == 0)
			$display("text_console_cursor_scroll verification clean");
		else
			$display("text_console_cursor_scroll verification failed");
		$finish;
	end
endmodule

@@ files.f @@
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_cursor.sv
rtl/text_console_cursor_scroll.sv
tb/tb.sv
